@@ rtl/lpp_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants, register codes and types for the line position PID block.
// No dependencies; every other file imports this package.
package lpp_pkg;

    localparam int SAMPLE_BITS = 10;
    localparam int GAIN_W      = 8;
    localparam int CFG_DATA_W  = (SAMPLE_BITS > GAIN_W) ? SAMPLE_BITS : GAIN_W;
    localparam int CFG_IDX_W   = 2;
    localparam int MAG_W       = 3;
    localparam int ERR_W       = 4;
    localparam int DIFF_W      = 5;
    localparam int INTEG_W     = 16;
    localparam int DRIVE_W     = 24;

    localparam logic [SAMPLE_BITS-1:0] THRESHOLD_RESET = SAMPLE_BITS'(500);
    localparam logic [GAIN_W-1:0]      GAIN_P_RESET    = GAIN_W'(50);
    localparam logic [GAIN_W-1:0]      GAIN_I_RESET    = '0;
    localparam logic [GAIN_W-1:0]      GAIN_D_RESET    = '0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD = 2'd0,
        CFG_GAIN_P    = 2'd1,
        CFG_GAIN_I    = 2'd2,
        CFG_GAIN_D    = 2'd3
    } t_cfg_idx;

    // bits[2] is the outer sensor of a side, bits[0] the inner one
    typedef struct packed {
        logic [2:0]       bits;
        logic [MAG_W-1:0] mag;
    } t_lane_res;

    typedef struct packed {
        logic [GAIN_W-1:0] gain_p;
        logic [GAIN_W-1:0] gain_i;
        logic [GAIN_W-1:0] gain_d;
    } t_gains;

endpackage

@@ rtl/line_position_pid.sv @@
`timescale 1ns / 1ps
// Top level of the line position PID block: configuration registers, lanes, merge.
// Depends on lpp_pkg, lpp_lane and lpp_merge.
//
// Takes one set of six sensor samples per clock while o_stall is low and returns one drive
// value per set. A set passes through the lane register, the error stage, the product stage
// and the output register, and transfers out when the output is not stalled. The error stage
// updates the integral and previous error as it takes each set, which sets the rate of one set
// per cycle; the products and their sum follow in two further registered stages. Each stage
// holds its item while the next is full, so a waiting result does not stop new transfers until
// the pipeline fills. Write the configuration registers only while the block is empty.
module line_position_pid
    import lpp_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic [SAMPLE_BITS-1:0]    i_sample_l1,
    input  logic [SAMPLE_BITS-1:0]    i_sample_l2,
    input  logic [SAMPLE_BITS-1:0]    i_sample_l3,
    input  logic [SAMPLE_BITS-1:0]    i_sample_r1,
    input  logic [SAMPLE_BITS-1:0]    i_sample_r2,
    input  logic [SAMPLE_BITS-1:0]    i_sample_r3,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic signed [DRIVE_W-1:0] o_drive,
    output logic [5:0]                o_line_bits,
    output logic signed [ERR_W-1:0]   o_position_error
);

    logic [SAMPLE_BITS-1:0] r_threshold;
    t_gains                 r_gains;

    t_lane_res              w_left, w_right;
    logic                   r_v1;
    logic [5:0]             r_bits1;
    logic [MAG_W-1:0]       r_mag_l1, r_mag_r1;
    logic                   w_merge_stall;
    logic                   w_rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold    <= THRESHOLD_RESET;
            r_gains.gain_p <= GAIN_P_RESET;
            r_gains.gain_i <= GAIN_I_RESET;
            r_gains.gain_d <= GAIN_D_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_THRESHOLD: r_threshold    <= i_cfg_data[SAMPLE_BITS-1:0];
                CFG_GAIN_P:    r_gains.gain_p <= i_cfg_data[GAIN_W-1:0];
                CFG_GAIN_I:    r_gains.gain_i <= i_cfg_data[GAIN_W-1:0];
                CFG_GAIN_D:    r_gains.gain_d <= i_cfg_data[GAIN_W-1:0];
                default:       r_threshold    <= r_threshold;
            endcase
        end
    end

    lpp_lane u_lane_left (
        .i_threshold (r_threshold),
        .i_outer     (i_sample_l1),
        .i_middle    (i_sample_l2),
        .i_inner     (i_sample_l3),
        .o_res       (w_left)
    );

    lpp_lane u_lane_right (
        .i_threshold (r_threshold),
        .i_outer     (i_sample_r3),
        .i_middle    (i_sample_r2),
        .i_inner     (i_sample_r1),
        .o_res       (w_right)
    );

    assign w_rdy1  = !r_v1 || !w_merge_stall;
    assign o_stall = !w_rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (w_rdy1) begin
            r_v1 <= i_valid;
        end
    end

    // right lane counts outer to inner, so flip it back to R1 R2 R3
    always_ff @(posedge i_clk) begin
        if (i_valid && w_rdy1) begin
            r_bits1  <= {w_left.bits, w_right.bits[0], w_right.bits[1], w_right.bits[2]};
            r_mag_l1 <= w_left.mag;
            r_mag_r1 <= w_right.mag;
        end
    end

    lpp_merge u_merge (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (r_v1),
        .o_stall          (w_merge_stall),
        .i_line_bits      (r_bits1),
        .i_mag_l          (r_mag_l1),
        .i_mag_r          (r_mag_r1),
        .i_gains          (r_gains),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_drive          (o_drive),
        .o_line_bits      (o_line_bits),
        .o_position_error (o_position_error)
    );

    a_err_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_position_error >= -4 && o_position_error <= 4))
        else $error("position error out of range");

    a_no_line_no_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_line_bits == 6'b000000) |-> (o_position_error == '0))
        else $error("error without any sensor on the line");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result present straight after reset");

    a_stall_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_v1 && o_valid && i_stall))
        else $error("input stalled with room in the pipeline");

endmodule

@@ rtl/lpp_lane.sv @@
`timescale 1ns / 1ps
// One side of the sensor bar: threshold compare and position magnitude.
// Depends on lpp_pkg.
module lpp_lane
    import lpp_pkg::*;
(
    input  logic [SAMPLE_BITS-1:0] i_threshold,
    input  logic [SAMPLE_BITS-1:0] i_outer,
    input  logic [SAMPLE_BITS-1:0] i_middle,
    input  logic [SAMPLE_BITS-1:0] i_inner,
    output t_lane_res              o_res
);

    logic [2:0] w_bits;

    assign w_bits = {i_outer < i_threshold, i_middle < i_threshold, i_inner < i_threshold};

    always_comb begin
        o_res.bits = w_bits;
        case (w_bits)
            3'b100:  o_res.mag = MAG_W'(1);
            3'b010:  o_res.mag = MAG_W'(2);
            3'b001:  o_res.mag = MAG_W'(3);
            3'b110:  o_res.mag = MAG_W'(4);
            default: o_res.mag = '0;
        endcase
    end

endmodule

@@ rtl/lpp_merge.sv @@
`timescale 1ns / 1ps
// Merge of the two lanes: error, integral and derivative state, PID products and sum.
// Depends on lpp_pkg.
module lpp_merge
    import lpp_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic [5:0]                i_line_bits,
    input  logic [MAG_W-1:0]          i_mag_l,
    input  logic [MAG_W-1:0]          i_mag_r,
    input  t_gains                    i_gains,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic signed [DRIVE_W-1:0] o_drive,
    output logic [5:0]                o_line_bits,
    output logic signed [ERR_W-1:0]   o_position_error
);

    localparam int PP_W  = GAIN_W + 1 + ERR_W;
    localparam int PI_W  = GAIN_W + 1 + INTEG_W;
    localparam int PD_W  = GAIN_W + 1 + DIFF_W;
    localparam int SUM_W = PI_W + 1;

    logic                      r_v2, r_v3, r_v4;
    logic                      w_rdy2, w_rdy3, w_rdy4, w_load2;

    logic signed [ERR_W-1:0]   r_prev;
    logic signed [INTEG_W-1:0] r_integ;

    logic signed [ERR_W-1:0]   n_err;
    logic signed [DIFF_W-1:0]  n_diff;
    logic signed [INTEG_W:0]   n_isum;
    logic signed [INTEG_W-1:0] n_integ;

    logic signed [ERR_W-1:0]   r_err2;
    logic signed [DIFF_W-1:0]  r_diff2;
    logic signed [INTEG_W-1:0] r_integ2;
    logic [5:0]                r_bits2;

    logic signed [PP_W-1:0]    r_pp3;
    logic signed [PI_W-1:0]    r_pi3;
    logic signed [PD_W-1:0]    r_pd3;
    logic signed [ERR_W-1:0]   r_err3;
    logic [5:0]                r_bits3;

    logic signed [SUM_W-1:0]   n_sum;

    assign w_rdy4  = !r_v4 || !i_stall;
    assign w_rdy3  = !r_v3 || w_rdy4;
    assign w_rdy2  = !r_v2 || w_rdy3;
    assign o_stall = !w_rdy2;
    assign w_load2 = i_valid && w_rdy2;

    assign n_err  = $signed({1'b0, i_mag_l}) - $signed({1'b0, i_mag_r});
    assign n_diff = DIFF_W'(n_err) - DIFF_W'(r_prev);
    assign n_isum = (INTEG_W+1)'(r_integ) + (INTEG_W+1)'(n_err);

    always_comb begin
        if (n_isum > $signed((INTEG_W+1)'(32767))) begin
            n_integ = INTEG_W'(32767);
        end else if (n_isum < -$signed((INTEG_W+1)'(32767))) begin
            n_integ = -$signed(INTEG_W'(32767));
        end else begin
            n_integ = n_isum[INTEG_W-1:0];
        end
    end

    assign n_sum = SUM_W'(r_pp3) + SUM_W'(r_pi3) + SUM_W'(r_pd3);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
            r_v4    <= 1'b0;
            r_prev  <= '0;
            r_integ <= '0;
        end else begin
            if (w_rdy2) begin
                r_v2 <= i_valid;
            end
            if (w_load2) begin
                r_prev  <= n_err;
                r_integ <= n_integ;
            end
            if (w_rdy3) begin
                r_v3 <= r_v2;
            end
            if (w_rdy4) begin
                r_v4 <= r_v3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load2) begin
            r_err2   <= n_err;
            r_diff2  <= n_diff;
            r_integ2 <= r_integ;
            r_bits2  <= i_line_bits;
        end
        if (r_v2 && w_rdy3) begin
            r_pp3   <= PP_W'($signed({1'b0, i_gains.gain_p})) * PP_W'(r_err2);
            r_pi3   <= PI_W'($signed({1'b0, i_gains.gain_i})) * PI_W'(r_integ2);
            r_pd3   <= PD_W'($signed({1'b0, i_gains.gain_d})) * PD_W'(r_diff2);
            r_err3  <= r_err2;
            r_bits3 <= r_bits2;
        end
        if (r_v3 && w_rdy4) begin
            o_drive          <= n_sum[DRIVE_W-1:0];
            o_line_bits      <= r_bits3;
            o_position_error <= r_err3;
        end
    end

    assign o_valid = r_v4;

endmodule

@@ tb/line_position_pid_tb.sv @@
`timescale 1ns / 1ps
// Testbench for line_position_pid: directed, random and integral swing tests.
// Each transfer out is checked against a local predictor. Depends on lpp_pkg and the RTL top.
module line_position_pid_tb;
    import lpp_pkg::*;

    localparam int IDLE_LIMIT    = 1000;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_ITEMS   = 300;
    localparam int INTEG_MAX     = 32767;
    localparam int SWING_ITEMS   = 16;

    typedef logic [SAMPLE_BITS-1:0] t_sample_set [6];

    typedef struct packed {
        logic signed [DRIVE_W-1:0] drive;
        logic [5:0]                line_bits;
        logic signed [ERR_W-1:0]   position_error;
    } t_steer;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_cfg_we;
    logic [CFG_IDX_W-1:0]      i_cfg_idx;
    logic [CFG_DATA_W-1:0]     i_cfg_data;
    logic                      i_valid;
    logic                      o_stall;
    logic [SAMPLE_BITS-1:0]    i_sample_l1;
    logic [SAMPLE_BITS-1:0]    i_sample_l2;
    logic [SAMPLE_BITS-1:0]    i_sample_l3;
    logic [SAMPLE_BITS-1:0]    i_sample_r1;
    logic [SAMPLE_BITS-1:0]    i_sample_r2;
    logic [SAMPLE_BITS-1:0]    i_sample_r3;
    logic                      o_valid;
    logic                      i_stall = 1'b0;
    logic signed [DRIVE_W-1:0] o_drive;
    logic [5:0]                o_line_bits;
    logic signed [ERR_W-1:0]   o_position_error;

    t_steer steer_q[$];
    int     fail_count    = 0;
    int     idle_cycles   = 0;
    int     send_idle_pct = 0;
    int     stall_pct     = 0;

    logic [SAMPLE_BITS-1:0] thr_m;
    logic [GAIN_W-1:0]      kp_m;
    logic [GAIN_W-1:0]      ki_m;
    logic [GAIN_W-1:0]      kd_m;
    int                     prev_err_m;
    int                     integral_m;

    line_position_pid u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_sample_l1      (i_sample_l1),
        .i_sample_l2      (i_sample_l2),
        .i_sample_l3      (i_sample_l3),
        .i_sample_r1      (i_sample_r1),
        .i_sample_r2      (i_sample_r2),
        .i_sample_r3      (i_sample_r3),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_drive          (o_drive),
        .o_line_bits      (o_line_bits),
        .o_position_error (o_position_error)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_steer predict_steering(t_sample_set s);
        t_steer     r;
        logic [5:0] bits;
        int         k;
        int         err;
        int         drv;
        int         nxt;
        for (k = 0; k < 6; k++) begin
            bits[5-k] = (s[k] < thr_m);
        end
        case (bits[5:3])
            3'b100:  err = 1;
            3'b010:  err = 2;
            3'b001:  err = 3;
            3'b110:  err = 4;
            default: err = 0;
        endcase
        case (bits[2:0])
            3'b001:  err -= 1;
            3'b010:  err -= 2;
            3'b100:  err -= 3;
            3'b011:  err -= 4;
            default: ;
        endcase
        drv = int'(kp_m) * err + int'(ki_m) * integral_m + int'(kd_m) * (err - prev_err_m);
        nxt = integral_m + err;
        if (nxt > INTEG_MAX) begin
            nxt = INTEG_MAX;
        end
        if (nxt < -INTEG_MAX) begin
            nxt = -INTEG_MAX;
        end
        integral_m = nxt;
        prev_err_m = err;
        r.drive          = drv[DRIVE_W-1:0];
        r.line_bits      = bits;
        r.position_error = err[ERR_W-1:0];
        return r;
    endfunction

    // tight: place each sample right at the threshold edge
    function automatic t_sample_set make_pattern(logic [5:0] bits, bit tight);
        t_sample_set s;
        int          k;
        for (k = 0; k < 6; k++) begin
            if (bits[5-k] && thr_m != 0) begin
                s[k] = tight ? thr_m - 1'b1
                             : SAMPLE_BITS'($urandom_range(int'(thr_m) - 1, 0));
            end else begin
                s[k] = tight ? thr_m
                             : SAMPLE_BITS'($urandom_range((1 << SAMPLE_BITS) - 1,
                                                           int'(thr_m)));
            end
        end
        return s;
    endfunction

    function automatic t_sample_set random_samples();
        t_sample_set s;
        int          k;
        if ($urandom_range(3) == 0) begin
            for (k = 0; k < 6; k++) begin
                s[k] = SAMPLE_BITS'($urandom_range((1 << SAMPLE_BITS) - 1, 0));
            end
        end else begin
            s = make_pattern(6'($urandom_range(63, 0)), 1'b0);
        end
        return s;
    endfunction

    task automatic send_samples(t_sample_set s);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_sample_l1 <= s[0];
        i_sample_l2 <= s[1];
        i_sample_l3 <= s[2];
        i_sample_r1 <= s[3];
        i_sample_r2 <= s[4];
        i_sample_r3 <= s[5];
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        steer_q.push_back(predict_steering(s));
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        while (steer_q.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic settle();
        drain_results();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic put_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        case (idx)
            CFG_THRESHOLD: thr_m = val[SAMPLE_BITS-1:0];
            CFG_GAIN_P:    kp_m  = val[GAIN_W-1:0];
            CFG_GAIN_I:    ki_m  = val[GAIN_W-1:0];
            CFG_GAIN_D:    kd_m  = val[GAIN_W-1:0];
            default:       ;
        endcase
    endtask

    task automatic write_config(logic [CFG_DATA_W-1:0] thr, logic [CFG_DATA_W-1:0] kp,
                                logic [CFG_DATA_W-1:0] ki, logic [CFG_DATA_W-1:0] kd);
        settle();
        put_reg(CFG_THRESHOLD, thr);
        put_reg(CFG_GAIN_P, kp);
        put_reg(CFG_GAIN_I, ki);
        put_reg(CFG_GAIN_D, kd);
        i_cfg_we <= 1'b0;
    endtask

    task automatic test_reset_values();
        send_samples('{default: 10'd0});
        send_samples('{default: 10'd1023});
        send_samples('{10'd499, 10'd500, 10'd500, 10'd500, 10'd500, 10'd500});
        send_samples('{10'd1023, 10'd1023, 10'd1023, 10'd499, 10'd1023, 10'd1023});
        send_samples('{10'd500, 10'd499, 10'd1023, 10'd1023, 10'd500, 10'd499});
    endtask

    task automatic test_directed_patterns();
        int p;
        write_config(10'd1023, 10'd255, 10'd255, 10'd255);
        for (p = 0; p < 8; p++) begin
            send_samples(make_pattern({p[2:0], 3'(7 - p)}, 1'b1));
        end
        write_config(10'd0, 10'h3FF, 10'h2AA, 10'h155);
        send_samples('{default: 10'd0});
        send_samples('{default: 10'd1023});
        write_config(10'd1, 10'd0, 10'd0, 10'd0);
        send_samples(make_pattern(6'b010100, 1'b1));
        send_samples(make_pattern(6'b110011, 1'b1));
        send_samples(make_pattern(6'b111111, 1'b1));
    endtask

    task automatic test_random_traffic(int idle_pct, int stall_in_pct);
        int n;
        send_idle_pct = idle_pct;
        stall_pct     = stall_in_pct;
        for (n = 0; n < PHASE_ITEMS; n++) begin
            if (n == PHASE_ITEMS / 2) begin
                drain_results();
                @(negedge i_clk);
            end
            send_samples(random_samples());
        end
    endtask

    // push the integral hard one way, then the other, then back
    task automatic test_integral_swing();
        write_config(CFG_DATA_W'($urandom_range(1023, 1)),
                     CFG_DATA_W'($urandom_range(1023, 0)), 10'd255,
                     CFG_DATA_W'($urandom_range(1023, 0)));
        send_idle_pct = 0;
        stall_pct     = 0;
        repeat (SWING_ITEMS) send_samples(make_pattern(6'b110000, 1'b0));
        repeat (2 * SWING_ITEMS) send_samples(make_pattern(6'b000011, 1'b0));
        repeat (SWING_ITEMS) send_samples(make_pattern(6'b110000, 1'b0));
    endtask

    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge i_clk) begin : check_transfer
        t_steer want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (steer_q.size() == 0) begin
                $error("result with nothing expected: drive %0d", o_drive);
                fail_count++;
            end else begin
                want = steer_q.pop_front();
                if (o_drive !== want.drive) begin
                    $error("drive: expected %0d, actual %0d", want.drive, o_drive);
                    fail_count++;
                end
                if (o_line_bits !== want.line_bits) begin
                    $error("line_bits: expected %b, actual %b", want.line_bits, o_line_bits);
                    fail_count++;
                end
                if (o_position_error !== want.position_error) begin
                    $error("position_error: expected %0d, actual %0d",
                           want.position_error, o_position_error);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("[line_position_pid] ERROR");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = CFG_THRESHOLD;
        i_cfg_data  = '0;
        i_valid     = 1'b0;
        i_sample_l1 = '0;
        i_sample_l2 = '0;
        i_sample_l3 = '0;
        i_sample_r1 = '0;
        i_sample_r2 = '0;
        i_sample_r3 = '0;
        thr_m       = THRESHOLD_RESET;
        kp_m        = GAIN_P_RESET;
        ki_m        = GAIN_I_RESET;
        kd_m        = GAIN_D_RESET;
        prev_err_m  = 0;
        integral_m  = 0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_values();
        test_directed_patterns();
        write_config(CFG_DATA_W'($urandom_range(1023, 0)), CFG_DATA_W'($urandom_range(1023, 0)),
                     CFG_DATA_W'($urandom_range(1023, 0)), CFG_DATA_W'($urandom_range(1023, 0)));
        test_random_traffic(0, 0);
        write_config(10'd1023, 10'd255, 10'd255, 10'd255);
        test_random_traffic(50, 0);
        write_config(CFG_DATA_W'($urandom_range(1023, 0)), 10'd0,
                     CFG_DATA_W'($urandom_range(1023, 0)), 10'd255);
        test_random_traffic(0, 50);
        write_config(CFG_DATA_W'($urandom_range(1023, 0)), CFG_DATA_W'($urandom_range(1023, 0)),
                     CFG_DATA_W'($urandom_range(1023, 0)), CFG_DATA_W'($urandom_range(1023, 0)));
        test_random_traffic(25, 25);
        test_integral_swing();
        settle();

        if (fail_count == 0 && steer_q.size() == 0) begin
            $display("[line_position_pid] OK");
        end else begin
            $display("[line_position_pid] ERROR");
        end
        $finish;
    end

endmodule
